FILE: hw/rtl/nlm_pkg.sv
// Shared types and constants for the nearest landmark match core.
// Used by every module under hw/rtl; depends on nothing else.
package nlm_pkg;

    // Table geometry.
    localparam int REF_DEPTH = 32;
    localparam int REF_AW    = 5;
    localparam int CNT_W     = 6;

    // Coordinate and distance widths.
    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ABS_W   = COORD_W;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int DIST_W  = 46;

    // Threshold after reset: 5000000 squared.
    localparam logic [DIST_W-1:0] THRESH_RESET = 46'd25000000000000;

    // Opcodes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE_REFS = 1'b0;
    localparam logic CFG_MAX_SQ      = 1'b1;

    // One classified command between the front and the back.
    typedef struct packed {
        logic                      is_query;
        logic [REF_AW-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } cmd_t;

    // One query result.
    typedef struct packed {
        logic              found;
        logic [REF_AW-1:0] index;
        logic [DIST_W-1:0] sq_dist;
    } result_t;

    // Scan engine states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } scan_state_t;

endpackage

FILE: hw/rtl/nearest_landmark_match_core.sv
// Top level of the nearest landmark match core: config registers and wiring.
// Depends on nlm_pkg, nlm_front, nlm_back and nlm_result_queue.
//
// Usage:
//   Input channel (push/full): each beat is a load (opcode 0) that writes
//   ref_slot of the landmark table, or a query (opcode 1) with an observed
//   point. Loads give no result; each query gives one result beat.
//   Result channel (empty/pop): match_found, nearest_index and
//   squared_distance of the oldest finished query while empty is low.
//   Config channel (cfg_valid/cfg_ready): index 0 is active_refs, index 1 is
//   max_sq_distance. cfg_ready is always high; write only while idle.
// Flow:
//   A two-entry command queue feeds the scan engine. A load is written
//   into the table straight from the idle state. A query scans
//   N = min(active_refs, 32) table entries and goes straight to its result
//   when N is 0; the single table read port delivers one entry per cycle
//   into a four-stage distance pipeline. The result is on the ports right
//   after the edge that writes it into the result queue if that queue was
//   empty. The engine takes no new command until the current query is done.
// Reset: queues empty, active_refs 0, threshold 25000000000000. The table is
//   not cleared and no clearing pass runs.
// Stall: a stalled receiver fills the two-entry result queue; the engine
//   then holds the next query, the command queue fills and full goes high.
module nearest_landmark_match_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [nlm_pkg::REF_AW-1:0]  ref_slot,
    input  logic signed [nlm_pkg::COORD_W-1:0] coord_x,
    input  logic signed [nlm_pkg::COORD_W-1:0] coord_y,
    output logic                        empty,
    input  logic                        pop,
    output logic                        match_found,
    output logic [nlm_pkg::REF_AW-1:0]  nearest_index,
    output logic [nlm_pkg::DIST_W-1:0]  squared_distance,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [nlm_pkg::DIST_W-1:0]  cfg_data
);
    import nlm_pkg::*;

    logic [CNT_W-1:0]  active_refs_reg;
    logic [DIST_W-1:0] max_sq_reg;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_take;
    logic    res_space;
    logic    res_push;
    result_t res;
    result_t head;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_refs_reg <= '0;
            max_sq_reg      <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ACTIVE_REFS: active_refs_reg <= cfg_data[CNT_W-1:0];
                CFG_MAX_SQ:      max_sq_reg      <= cfg_data;
                default:         max_sq_reg      <= max_sq_reg;
            endcase
        end
    end

    nlm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .ref_slot  (ref_slot),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    nlm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_take        (cmd_take),
        .res_space       (res_space),
        .active_refs     (active_refs_reg),
        .max_sq_distance (max_sq_reg),
        .res_push        (res_push),
        .res             (res)
    );

    nlm_result_queue u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_space (res_space),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign match_found      = head.found;
    assign nearest_index    = head.index;
    assign squared_distance = head.sq_dist;

endmodule

FILE: hw/rtl/nlm_front.sv
// Front end: accepts input beats, classifies them and queues commands.
// Depends on nlm_pkg for cmd_t and the opcode constants.
module nlm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [nlm_pkg::REF_AW-1:0]  ref_slot,
    input  logic signed [nlm_pkg::COORD_W-1:0] coord_x,
    input  logic signed [nlm_pkg::COORD_W-1:0] coord_y,
    output logic                        cmd_valid,
    output nlm_pkg::cmd_t               cmd,
    input  logic                        cmd_take
);
    import nlm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       in_cmd;

    // Classify the incoming beat.
    always_comb
    begin
        in_cmd.is_query = (opcode == OP_QUERY);
        in_cmd.slot     = ref_slot;
        in_cmd.x        = coord_x;
        in_cmd.y        = coord_y;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hw/rtl/nlm_back.sv
// Back end: holds the landmark table, executes loads and scans it for queries.
// Depends on nlm_pkg for cmd_t, result_t, scan_state_t and widths.
module nlm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  nlm_pkg::cmd_t               cmd,
    output logic                        cmd_take,
    input  logic                        res_space,
    input  logic [nlm_pkg::CNT_W-1:0]   active_refs,
    input  logic [nlm_pkg::DIST_W-1:0]  max_sq_distance,
    output logic                        res_push,
    output nlm_pkg::result_t            res
);
    import nlm_pkg::*;

    // Landmark table: x in the upper half, y in the lower half.
    logic [2*COORD_W-1:0] ref_mem [REF_DEPTH];

    scan_state_t state_reg;
    scan_state_t state_next;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_eff;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic [DIST_W-1:0] best_reg;
    logic              found_reg;
    logic [REF_AW-1:0] bidx_reg;

    // Pipeline registers.
    logic [2*COORD_W-1:0] rd_data_reg;
    logic                 s1_valid_reg;
    logic [REF_AW-1:0]    s1_idx_reg;
    logic                 s2_valid_reg;
    logic [REF_AW-1:0]    s2_idx_reg;
    logic [ABS_W-1:0]     dx_reg;
    logic [ABS_W-1:0]     dy_reg;
    logic                 s3_valid_reg;
    logic [REF_AW-1:0]    s3_idx_reg;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;

    logic wr_en;
    logic start;
    logic issue;
    logic last_issue;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic [DIFF_W-1:0] abs_x;
    logic [DIFF_W-1:0] abs_y;
    logic [SUM_W-1:0]  sum;
    logic              closer;

    // Entries scanned per query, saturated at the table depth.
    assign count_eff = (active_refs > CNT_W'(REF_DEPTH)) ? CNT_W'(REF_DEPTH) : active_refs;
    assign last_issue = ((scan_cnt_reg + CNT_W'(1)) == count_reg);

    // Next state and command handshake.
    always_comb
    begin
        state_next = state_reg;
        cmd_take   = 1'b0;
        wr_en      = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_query)
                    begin
                        cmd_take = 1'b1;
                        wr_en    = 1'b1;
                    end
                    else if (res_space)
                    begin
                        cmd_take   = 1'b1;
                        start      = 1'b1;
                        state_next = (count_eff == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                issue = 1'b1;
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Absolute coordinate differences; each fits in COORD_W bits.
    always_comb
    begin
        diff_x = $signed({rd_data_reg[2*COORD_W-1], rd_data_reg[2*COORD_W-1:COORD_W]})
               - $signed({qx_reg[COORD_W-1], qx_reg});
        diff_y = $signed({rd_data_reg[COORD_W-1], rd_data_reg[COORD_W-1:0]})
               - $signed({qy_reg[COORD_W-1], qy_reg});
        abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
        abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    end

    // Final add and strict compare against the best distance so far.
    assign sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign closer = (DIST_W'(sum) < best_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (start)
            begin
                scan_cnt_reg <= '0;
                count_reg    <= count_eff;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (s3_valid_reg && closer)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg   <= cmd.x;
            qy_reg   <= cmd.y;
            best_reg <= max_sq_distance;
            bidx_reg <= '0;
        end
        else if (s3_valid_reg && closer)
        begin
            best_reg <= DIST_W'(sum);
            bidx_reg <= s3_idx_reg;
        end
        s1_idx_reg <= scan_cnt_reg[REF_AW-1:0];
        s2_idx_reg <= s1_idx_reg;
        dx_reg     <= abs_x[ABS_W-1:0];
        dy_reg     <= abs_y[ABS_W-1:0];
        s3_idx_reg <= s2_idx_reg;
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
    end

    // Table memory: one write port for loads, one registered read for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[cmd.slot] <= {cmd.x, cmd.y};
        end
        if (issue)
        begin
            rd_data_reg <= ref_mem[scan_cnt_reg[REF_AW-1:0]];
        end
    end

    // Result of the finished query.
    always_comb
    begin
        res.found   = found_reg;
        res.index   = bidx_reg;
        res.sq_dist = best_reg;
    end

endmodule

FILE: hw/rtl/nlm_result_queue.sv
// Two-entry result queue that decouples the scan engine from the receiver.
// Depends on nlm_pkg for result_t.
module nlm_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  nlm_pkg::result_t res,
    output logic             res_space,
    output logic             empty,
    input  logic             pop,
    output nlm_pkg::result_t head
);
    import nlm_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign empty     = (cnt_reg == 2'd0);
    assign res_space = (cnt_reg != 2'd2);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = res_push && res_space;
    assign do_pop    = pop && !empty;

    // Fill count update.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Result storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

FILE: hw/rtl/nlm_checker.sv
// Port-level checks for the nearest landmark match core, bound to the top.
// Depends on nlm_pkg for widths.
module nlm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic                        match_found,
    input logic [nlm_pkg::REF_AW-1:0]  nearest_index,
    input logic [nlm_pkg::DIST_W-1:0]  squared_distance
);
    import nlm_pkg::*;

    // A waiting result beat holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(match_found)
            && $stable(nearest_index) && $stable(squared_distance)))
        else $error("result beat changed while stalled");

    // A miss always reports index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !match_found) |-> (nearest_index == '0))
        else $error("miss with nonzero index");

    // A hit distance is a sum of two squared coordinate differences.
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && match_found) |-> (squared_distance[DIST_W-1:SUM_W] == '0))
        else $error("hit distance out of range");

    // The command queue only fills because of an accepted input beat.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

endmodule

bind nearest_landmark_match_core nlm_checker u_nlm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .match_found      (match_found),
    .nearest_index    (nearest_index),
    .squared_distance (squared_distance)
);
